FILE: hw/rtl/exl_pkg.sv
// Shared types, token codes and character classification for the expression lexer.
// Used by expression_language_lexer_unit and its checker; depends on nothing else.

package exl_pkg;

   // Longest lexeme length that a word token reports before it saturates.
   localparam int MAX_LEXEME = 255;
   localparam logic [7:0] LEN_CAP = 8'((MAX_LEXEME < 255) ? MAX_LEXEME : 255);

   // Number of leading word bytes kept for keyword matching.
   localparam int HEAD_BYTES = 5;

   // Token kind codes.
   localparam logic [4:0] TK_EOI     = 5'd0;
   localparam logic [4:0] TK_SEMI    = 5'd1;
   localparam logic [4:0] TK_PLUS    = 5'd2;
   localparam logic [4:0] TK_MINUS   = 5'd3;
   localparam logic [4:0] TK_TIMES   = 5'd4;
   localparam logic [4:0] TK_DIV     = 5'd5;
   localparam logic [4:0] TK_MOD     = 5'd6;
   localparam logic [4:0] TK_GT      = 5'd7;
   localparam logic [4:0] TK_LT      = 5'd8;
   localparam logic [4:0] TK_EQ      = 5'd9;
   localparam logic [4:0] TK_LPAREN  = 5'd10;
   localparam logic [4:0] TK_RPAREN  = 5'd11;
   localparam logic [4:0] TK_ASSIGN  = 5'd12;
   localparam logic [4:0] TK_IF      = 5'd13;
   localparam logic [4:0] TK_THEN    = 5'd14;
   localparam logic [4:0] TK_WHILE   = 5'd15;
   localparam logic [4:0] TK_DO      = 5'd16;
   localparam logic [4:0] TK_BEGIN   = 5'd17;
   localparam logic [4:0] TK_END     = 5'd18;
   localparam logic [4:0] TK_ID      = 5'd19;
   localparam logic [4:0] TK_NUM     = 5'd20;
   localparam logic [4:0] TK_BADNUM  = 5'd21;
   localparam logic [4:0] TK_ILLEGAL = 5'd22;

   // Separator and special characters.
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_EQUALS  = 8'h3D;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_input;
   } req_payload_type;

   typedef struct packed {
      logic [4:0]  token_kind;
      logic [7:0]  token_length;
      logic [15:0] line_number;
      logic        last;
   } rsp_payload_type;

   typedef logic [HEAD_BYTES-1:0][7:0] word_head_type;

   function automatic logic is_letter(input logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   // Kind of a single-character token; anything unlisted is illegal.
   function automatic logic [4:0] single_char_kind(input logic [7:0] c);
      logic [4:0] kind;
      case (c)
         ";":     kind = TK_SEMI;
         "+":     kind = TK_PLUS;
         "-":     kind = TK_MINUS;
         "*":     kind = TK_TIMES;
         "/":     kind = TK_DIV;
         "%":     kind = TK_MOD;
         ">":     kind = TK_GT;
         "<":     kind = TK_LT;
         "=":     kind = TK_EQ;
         "(":     kind = TK_LPAREN;
         ")":     kind = TK_RPAREN;
         default: kind = TK_ILLEGAL;
      endcase
      return kind;
   endfunction

   // Kind of a finished word. Keywords match on the whole word, case-sensitively.
   function automatic logic [4:0] word_kind(input word_head_type h, input logic [7:0] n,
                                            input logic starts_digit,
                                            input logic letter_after);
      logic [4:0] kind;
      if (n == 8'd2 && h[0] == "i" && h[1] == "f") begin
         kind = TK_IF;
      end else if (n == 8'd4 && h[0] == "t" && h[1] == "h" && h[2] == "e"
                   && h[3] == "n") begin
         kind = TK_THEN;
      end else if (n == 8'd5 && h[0] == "w" && h[1] == "h" && h[2] == "i"
                   && h[3] == "l" && h[4] == "e") begin
         kind = TK_WHILE;
      end else if (n == 8'd2 && h[0] == "d" && h[1] == "o") begin
         kind = TK_DO;
      end else if (n == 8'd5 && h[0] == "b" && h[1] == "e" && h[2] == "g"
                   && h[3] == "i" && h[4] == "n") begin
         kind = TK_BEGIN;
      end else if (n == 8'd3 && h[0] == "e" && h[1] == "n" && h[2] == "d") begin
         kind = TK_END;
      end else if (!starts_digit) begin
         kind = TK_ID;
      end else if (letter_after) begin
         kind = TK_BADNUM;
      end else begin
         kind = TK_NUM;
      end
      return kind;
   endfunction

endpackage

FILE: hw/rtl/expression_language_lexer_unit.sv
// Streaming lexer top level: input register, one-pass token logic, result queue.
// Depends on exl_pkg for payload types, token codes and character functions.
//
//   Channel  Ports                           Direction  Carries
//   req      req_valid/req_stall/req_data    in         one character or end-of-input mark
//   rsp      rsp_valid/rsp_stall/rsp_data    out        one token per transfer
//
// One character is taken per cycle while req_stall is low; its tokens are written from the input
// register into a four-entry result queue and leave it at one per cycle while rsp_stall is low.
// Characters that make two tokens each are paced by the one-per-cycle output side,
// and any output stall backs up through the queue to the input.
// Reset is synchronous and clears the lexer state and the queue; no clearing pass.
// req_stall rises when the input register is full and the queue lacks room for two tokens.

module expression_language_lexer_unit (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  exl_pkg::req_payload_type req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output exl_pkg::rsp_payload_type rsp_data
);
   import exl_pkg::*;

   localparam int QDEPTH = 4;

   // Input register.
   logic            in_valid_ff, in_valid_in;
   req_payload_type in_data_ff;

   // Lexer state.
   logic          word_active_ff, word_active_in;
   logic          word_starts_digit_ff, word_starts_digit_in;
   logic          word_has_letter_after_ff, word_has_letter_after_in;
   logic [7:0]    word_count_ff, word_count_in;
   word_head_type word_head_ff, word_head_in;
   logic          colon_pending_ff, colon_pending_in;
   logic          line_has_content_ff, line_has_content_in;
   logic [15:0]   line_count_ff, line_count_in;

   // Result queue.
   rsp_payload_type queue_ff [QDEPTH];
   logic [1:0]      rd_ptr_ff, rd_ptr_in;
   logic [1:0]      wr_ptr_ff, wr_ptr_in;
   logic [2:0]      count_ff, count_in;

   logic            pop;
   logic            process;
   logic            take;
   logic [1:0]      n_res;
   rsp_payload_type res0, res1;

   logic [7:0]  c;
   logic        eoi;
   logic        word_char;
   logic        blank;
   logic [15:0] line_now;
   logic [4:0]  cur_word_kind;

   // Handshake and queue control.
   assign rsp_valid = (count_ff != 3'd0);
   assign rsp_data  = queue_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign process   = in_valid_ff && ((count_ff <= 3'd2) || ((count_ff == 3'd3) && pop));
   assign req_stall = in_valid_ff && !process;
   assign take      = req_valid && !req_stall;

   // Character classification for the item in the input register.
   assign c             = in_data_ff.char_code;
   assign eoi           = in_data_ff.end_of_input;
   assign word_char     = is_letter(c) || is_digit(c);
   assign blank         = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NEWLINE);
   assign cur_word_kind = word_kind(word_head_ff, word_count_ff, word_starts_digit_ff,
                                    word_has_letter_after_ff);

   // Line count after this character; a line is counted on its first nonblank character.
   always_comb begin
      line_now = line_count_ff;
      if (!eoi && !blank && !line_has_content_ff && (line_count_ff != 16'hFFFF)) begin
         line_now = 16'(line_count_ff + 16'd1);
      end
   end

   // Token logic for one character: next state and up to two tokens.
   always_comb begin
      logic done;
      done                     = 1'b0;
      n_res                    = 2'd0;
      res0                     = '0;
      res1                     = '0;
      word_active_in           = word_active_ff;
      word_starts_digit_in     = word_starts_digit_ff;
      word_has_letter_after_in = word_has_letter_after_ff;
      word_count_in            = word_count_ff;
      word_head_in             = word_head_ff;
      colon_pending_in         = colon_pending_ff;
      line_has_content_in      = line_has_content_ff;
      line_count_in            = line_now;

      if (eoi) begin
         // Flush a pending colon or word, then close the stream.
         if (colon_pending_ff) begin
            res0  = '{TK_ILLEGAL, 8'd1, line_count_ff, 1'b0};
            n_res = 2'd1;
         end
         if (word_active_ff) begin
            res0  = '{cur_word_kind, word_count_ff, line_count_ff, 1'b0};
            n_res = 2'd1;
         end
         if (n_res == 2'd0) begin
            res0 = '{TK_EOI, 8'd1, line_count_ff, 1'b0};
         end else begin
            res1 = '{TK_EOI, 8'd1, line_count_ff, 1'b0};
         end
         n_res                    = 2'(n_res + 2'd1);
         word_active_in           = 1'b0;
         word_starts_digit_in     = 1'b0;
         word_has_letter_after_in = 1'b0;
         word_count_in            = '0;
         word_head_in             = '0;
         colon_pending_in         = 1'b0;
         line_has_content_in      = 1'b0;
         line_count_in            = '0;
      end else begin
         // A pending colon becomes an assign or a lone illegal colon.
         if (colon_pending_ff) begin
            colon_pending_in = 1'b0;
            if (c == CH_EQUALS) begin
               res0 = '{TK_ASSIGN, 8'd2, line_now, 1'b0};
               done = 1'b1;
            end else begin
               res0 = '{TK_ILLEGAL, 8'd1, line_now, 1'b0};
            end
            n_res = 2'd1;
         end

         if (!done) begin
            if (!blank) begin
               line_has_content_in = 1'b1;
            end
            if (word_char) begin
               // Start or extend a word.
               if (!word_active_ff) begin
                  word_active_in           = 1'b1;
                  word_starts_digit_in     = is_digit(c);
                  word_has_letter_after_in = 1'b0;
                  word_count_in            = 8'd1;
                  word_head_in             = '0;
                  word_head_in[0]          = c;
               end else begin
                  if (word_count_ff < 8'(HEAD_BYTES)) begin
                     word_head_in[word_count_ff[2:0]] = c;
                  end
                  if (word_starts_digit_ff && is_letter(c)) begin
                     word_has_letter_after_in = 1'b1;
                  end
                  if (word_count_ff < LEN_CAP) begin
                     word_count_in = 8'(word_count_ff + 8'd1);
                  end
               end
            end else begin
               // A separator ends the word in progress.
               if (word_active_ff) begin
                  res0                     = '{cur_word_kind, word_count_ff, line_now, 1'b0};
                  n_res                    = 2'd1;
                  word_active_in           = 1'b0;
                  word_starts_digit_in     = 1'b0;
                  word_has_letter_after_in = 1'b0;
                  word_count_in            = '0;
                  word_head_in             = '0;
               end
               if (c == CH_NEWLINE) begin
                  line_has_content_in = 1'b0;
               end else if (!blank) begin
                  if (c == CH_COLON) begin
                     colon_pending_in = 1'b1;
                  end else if (n_res == 2'd0) begin
                     res0  = '{single_char_kind(c), 8'd1, line_now, 1'b0};
                     n_res = 2'd1;
                  end else begin
                     res1  = '{single_char_kind(c), 8'd1, line_now, 1'b0};
                     n_res = 2'd2;
                  end
               end
            end
         end
      end

      // Mark the final token of this character.
      if (n_res == 2'd1) begin
         res0.last = 1'b1;
      end else if (n_res == 2'd2) begin
         res1.last = 1'b1;
      end
   end

   // Input register and queue pointers.
   always_comb begin
      in_valid_in = in_valid_ff;
      if (process) begin
         in_valid_in = 1'b0;
      end
      if (take) begin
         in_valid_in = 1'b1;
      end
      rd_ptr_in = pop ? 2'(rd_ptr_ff + 2'd1) : rd_ptr_ff;
      wr_ptr_in = process ? 2'(wr_ptr_ff + n_res) : wr_ptr_ff;
      count_in  = 3'(count_ff + (process ? {1'b0, n_res} : 3'd0) - {2'b0, pop});
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff              <= 1'b0;
         rd_ptr_ff                <= '0;
         wr_ptr_ff                <= '0;
         count_ff                 <= '0;
         word_active_ff           <= 1'b0;
         word_starts_digit_ff     <= 1'b0;
         word_has_letter_after_ff <= 1'b0;
         word_count_ff            <= '0;
         word_head_ff             <= '0;
         colon_pending_ff         <= 1'b0;
         line_has_content_ff      <= 1'b0;
         line_count_ff            <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         rd_ptr_ff   <= rd_ptr_in;
         wr_ptr_ff   <= wr_ptr_in;
         count_ff    <= count_in;
         if (process) begin
            word_active_ff           <= word_active_in;
            word_starts_digit_ff     <= word_starts_digit_in;
            word_has_letter_after_ff <= word_has_letter_after_in;
            word_count_ff            <= word_count_in;
            word_head_ff             <= word_head_in;
            colon_pending_ff         <= colon_pending_in;
            line_has_content_ff      <= line_has_content_in;
            line_count_ff            <= line_count_in;
         end
      end
   end

   // Payload registers: input data and queue entries.
   always_ff @(posedge clock) begin
      if (take) begin
         in_data_ff <= req_data;
      end
      if (process && (n_res != 2'd0)) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (process && (n_res == 2'd2)) begin
         queue_ff[2'(wr_ptr_ff + 2'd1)] <= res1;
      end
   end

endmodule

FILE: hw/rtl/exl_checker.sv
// Port-level checks for expression_language_lexer_unit, attached with a bind.
// Depends on exl_pkg for the payload types and token codes.

module exl_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input exl_pkg::rsp_payload_type rsp_data
);
   import exl_pkg::*;

   // A stalled result holds until its transfer.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // The queue is empty right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // End-of-input is always the final token of its character, length one.
   a_eoi_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.token_kind == TK_EOI) |->
         rsp_data.last && (rsp_data.token_length == 8'd1))
      else $error("malformed end-of-input token");

   // An assign token spans two characters and ends its character's tokens.
   a_assign_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.token_kind == TK_ASSIGN) |->
         rsp_data.last && (rsp_data.token_length == 8'd2))
      else $error("malformed assign token");

   // Only defined token kinds and nonzero lengths appear.
   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.token_kind <= TK_ILLEGAL) && (rsp_data.token_length != 8'd0))
      else $error("token kind or length out of range");

endmodule

bind expression_language_lexer_unit exl_checker u_exl_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
